FILE: hw/rtl/lbs_pkg.sv
`default_nettype none

package lbs_pkg;

  localparam int CHANNELS = 5;
  localparam int KEY_CH   = 4;
  localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // command queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // phase lengths in 64 ms ticks
  localparam logic [6:0] TICKS_100MS  = 7'(100 / 64);
  localparam logic [6:0] TICKS_256MS  = 7'(256 / 64);
  localparam logic [6:0] TICKS_500MS  = 7'(500 / 64);
  localparam logic [6:0] TICKS_1000MS = 7'(1000 / 64);
  localparam logic [6:0] TICKS_2000MS = 7'(2000 / 64);
  localparam logic [6:0] TICKS_3000MS = 7'(3000 / 64);
  localparam logic [6:0] TICKS_5000MS = 7'(5000 / 64);
  localparam logic [6:0] TICKS_6000MS = 7'(6000 / 64);

  localparam logic [7:0]  REPEAT_FOREVER = 8'hFF;
  localparam logic [15:0] LED_ALL_ON     = 16'hFFFF;
  localparam logic [15:0] LED_ALL_OFF    = 16'h0000;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_TICK  = 2'd1,
    OP_QUERY = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    KIND_LED   = 2'd0,
    KIND_START = 2'd1,
    KIND_QUERY = 2'd2
  } kind_e;

  typedef enum logic {
    BK_IDLE,
    BK_SCAN
  } back_state_e;

  typedef struct packed {
    logic [1:0]  operation;
    logic [2:0]  channel;
    logic [15:0] pattern;
    logic [3:0]  mode;
    logic [7:0]  repeats;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] led_word;
    logic        accepted;
    logic        busy_res;
    logic        last;
  } out_item_t;

  typedef struct packed {
    op_e                 op;
    logic                ok;
    logic [CH_IDX_W-1:0] ch;
    logic [15:0]         pattern;
    logic [2:0]          mode_idx;
    logic [7:0]          repeats;
  } cmd_t;

  function automatic logic [6:0] on_ticks(input logic [2:0] idx);
    logic [6:0] t;
    case (idx)
      3'd0:    t = TICKS_1000MS;
      3'd1:    t = TICKS_256MS;
      3'd2:    t = TICKS_500MS;
      3'd3:    t = TICKS_3000MS;
      3'd4:    t = TICKS_5000MS;
      3'd5:    t = TICKS_1000MS;
      3'd6:    t = TICKS_2000MS;
      default: t = TICKS_500MS;
    endcase
    return t;
  endfunction

  function automatic logic [6:0] off_ticks(input logic [2:0] idx);
    logic [6:0] t;
    case (idx)
      3'd0:    t = TICKS_1000MS;
      3'd1:    t = TICKS_6000MS;
      3'd2:    t = TICKS_500MS;
      3'd3:    t = TICKS_100MS;
      3'd4:    t = TICKS_100MS;
      3'd5:    t = TICKS_1000MS;
      3'd6:    t = TICKS_2000MS;
      default: t = TICKS_500MS;
    endcase
    return t;
  endfunction

  function automatic logic [15:0] fixed_on(input logic [1:0] ch);
    logic [15:0] w;
    case (ch)
      2'd0:    w = 16'h04F1;
      2'd1:    w = 16'h011F;
      2'd2:    w = 16'h0400 | 16'h8000 | 16'h0200;
      default: w = 16'h2B54;
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/led_blink_sequencer.sv
`default_nettype none

// LED blink sequencer. Commands (start, tick, query) are taken on the input
// channel into a two-entry command queue and carried out in order; results
// leave through a registered output stage, so a new command can be taken
// while a result waits. A start or a query waits for a free output stage
// and then yields one registered beat. A tick leaves the queue and then
// walks the channels one per cycle, holding on a channel only while its
// LED beat waits on a stalled output; the tick keeps the executing stage
// until the walk is done. Ticks with no LED activity produce no beat; the
// last beat of each command carries last.
// Unknown operations are taken and dropped.
module led_blink_sequencer (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire lbs_pkg::in_item_t  in_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output lbs_pkg::out_item_t      out_data_o
);
  import lbs_pkg::*;

  logic push;
  cmd_t push_cmd;
  logic fifo_full;
  logic fifo_empty;
  logic pop;
  cmd_t head_cmd;

  lbs_front u_front (
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .fifo_full_i (fifo_full),
    .push_o      (push),
    .cmd_o       (push_cmd)
  );

  lbs_cmd_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_cmd),
    .full_o      (fifo_full),
    .pop_i       (pop),
    .empty_o     (fifo_empty),
    .pop_data_o  (head_cmd)
  );

  lbs_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fifo_empty_i (fifo_empty),
    .cmd_i        (head_cmd),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_o   (out_data_o)
  );

endmodule

`default_nettype wire

FILE: hw/rtl/lbs_front.sv
`default_nettype none

module lbs_front (
  input  wire logic            in_valid_i,
  output logic                 in_stall_o,
  input  wire lbs_pkg::in_item_t in_data_i,
  input  wire logic            fifo_full_i,
  output logic                 push_o,
  output lbs_pkg::cmd_t        cmd_o
);
  import lbs_pkg::*;

  logic known_op;
  logic ch_ok;
  logic mode_ok;

  assign in_stall_o = fifo_full_i;

  assign known_op = (in_data_i.operation == OP_START) ||
                    (in_data_i.operation == OP_TICK) ||
                    (in_data_i.operation == OP_QUERY);

  // unknown operations are taken and dropped here
  assign push_o = in_valid_i && !fifo_full_i && known_op;

  assign ch_ok   = (int'(in_data_i.channel) < CHANNELS);
  assign mode_ok = (in_data_i.mode >= 4'd1) && (in_data_i.mode <= 4'd8);

  always_comb begin
    cmd_o          = '0;
    cmd_o.op       = op_e'(in_data_i.operation);
    cmd_o.ok       = ch_ok && mode_ok;
    cmd_o.ch       = CH_IDX_W'(in_data_i.channel);
    cmd_o.pattern  = in_data_i.pattern;
    cmd_o.mode_idx = 3'(in_data_i.mode - 4'd1);
    cmd_o.repeats  = in_data_i.repeats;
  end

endmodule

`default_nettype wire

FILE: hw/rtl/lbs_cmd_fifo.sv
`default_nettype none

module lbs_cmd_fifo (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire lbs_pkg::cmd_t push_data_i,
  output logic               full_o,
  input  wire logic          pop_i,
  output logic               empty_o,
  output lbs_pkg::cmd_t      pop_data_o
);
  import lbs_pkg::*;

  cmd_t              entry_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;
  logic              do_push;
  logic              do_pop;

  assign full_o     = (count_q == QCNT_W'(QDEPTH));
  assign empty_o    = (count_q == '0);
  assign pop_data_o = entry_q[rd_ptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= QCNT_W'(QDEPTH))
    else $error("command queue count out of range");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("pop from empty command queue");
`endif

endmodule

`default_nettype wire

FILE: hw/rtl/lbs_back.sv
`default_nettype none

module lbs_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          fifo_empty_i,
  input  wire lbs_pkg::cmd_t cmd_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output lbs_pkg::out_item_t out_data_o
);
  import lbs_pkg::*;

  back_state_e         state_q, state_d;
  logic [CH_IDX_W-1:0] scan_q, scan_d;

  logic [6:0]  timer_q   [CHANNELS];
  logic [6:0]  timer_d   [CHANNELS];
  logic        lit_q     [CHANNELS];
  logic        lit_d     [CHANNELS];
  logic [7:0]  rep_q     [CHANNELS];
  logic [7:0]  rep_d     [CHANNELS];
  logic [2:0]  mode_q    [CHANNELS];
  logic [2:0]  mode_d    [CHANNELS];
  logic [15:0] pattern_q [CHANNELS];
  logic [15:0] pattern_d [CHANNELS];

  logic              out_valid_q;
  out_item_t         out_data_q;
  out_item_t         out_item;
  logic              out_load;
  logic              out_free;

  logic [CHANNELS-1:0] emits_v;
  logic [CHANNELS-1:0] later_v;
  logic [CHANNELS-1:0] busy_v;

  logic [2:0]  idx3;
  logic        is_fixed;
  logic        is_key;
  logic [6:0]  cur_t;
  logic [6:0]  cur_tn;
  logic        cur_lit;
  logic [7:0]  cur_rep;
  logic [7:0]  rep_n;
  logic [2:0]  cur_mode;
  logic [15:0] cur_pat;
  logic        emit_cur;
  logic [15:0] emit_word;

  assign out_free = !out_valid_q || !out_stall_i;

  // per-channel lookahead: channels do not affect each other within a tick
  always_comb begin
    for (int j = 0; j < CHANNELS; j++) begin
      emits_v[j] = (timer_q[j] == 7'd1) && (rep_q[j] != '0) &&
                   ((j < KEY_CH) ||
                    ((j == KEY_CH) && (!lit_q[j] || (rep_q[j] > 8'd1))));
      later_v[j] = (CH_IDX_W'(j) > scan_q);
      busy_v[j]  = (timer_q[j] != '0) || (rep_q[j] != '0);
    end
  end

  assign idx3     = 3'(scan_q);
  assign is_fixed = (int'(idx3) < KEY_CH);
  assign is_key   = (int'(idx3) == KEY_CH);
  assign cur_t    = timer_q[scan_q];
  assign cur_tn   = cur_t - 7'd1;
  assign cur_lit  = lit_q[scan_q];
  assign cur_rep  = rep_q[scan_q];
  assign cur_mode = mode_q[scan_q];
  assign cur_pat  = pattern_q[scan_q];
  assign emit_cur = emits_v[scan_q];
  assign rep_n    = (cur_rep != REPEAT_FOREVER) ? cur_rep - 8'd1 : cur_rep;

  always_comb begin
    if (!cur_lit) begin
      if (is_fixed) begin
        emit_word = fixed_on(idx3[1:0]);
      end else begin
        emit_word = (cur_rep < 8'd2) ? LED_ALL_OFF : cur_pat;
      end
    end else begin
      emit_word = is_fixed ? LED_ALL_OFF : LED_ALL_ON;
    end
  end

  always_comb begin
    state_d   = state_q;
    scan_d    = scan_q;
    pop_o     = 1'b0;
    out_load  = 1'b0;
    out_item  = '0;
    timer_d   = timer_q;
    lit_d     = lit_q;
    rep_d     = rep_q;
    mode_d    = mode_q;
    pattern_d = pattern_q;

    case (state_q)
      BK_IDLE: begin
        if (!fifo_empty_i) begin
          case (cmd_i.op)
            OP_TICK: begin
              pop_o   = 1'b1;
              scan_d  = '0;
              state_d = BK_SCAN;
            end
            OP_START: begin
              if (out_free) begin
                pop_o = 1'b1;
                for (int j = 0; j < CHANNELS; j++) begin
                  timer_d[j]   = '0;
                  lit_d[j]     = 1'b0;
                  rep_d[j]     = '0;
                  mode_d[j]    = '0;
                  pattern_d[j] = '0;
                end
                if (cmd_i.ok) begin
                  timer_d[cmd_i.ch]   = 7'd1;
                  rep_d[cmd_i.ch]     = cmd_i.repeats;
                  mode_d[cmd_i.ch]    = cmd_i.mode_idx;
                  pattern_d[cmd_i.ch] = cmd_i.pattern;
                end
                out_load          = 1'b1;
                out_item.kind     = KIND_START;
                out_item.accepted = cmd_i.ok;
                out_item.last     = 1'b1;
              end
            end
            OP_QUERY: begin
              if (out_free) begin
                pop_o             = 1'b1;
                out_load          = 1'b1;
                out_item.kind     = KIND_QUERY;
                out_item.busy_res = |busy_v;
                out_item.last     = 1'b1;
              end
            end
            default: pop_o = 1'b1;
          endcase
        end
      end
      BK_SCAN: begin
        // one channel per cycle; wait only when this channel has a beat to send and the output is stalled
        if (!emit_cur || out_free) begin
          if (cur_t != '0) begin
            timer_d[scan_q] = cur_tn;
            if ((cur_tn == '0) && (cur_rep != '0)) begin
              if (!cur_lit) begin
                lit_d[scan_q]   = 1'b1;
                timer_d[scan_q] = on_ticks(cur_mode);
                if (is_key && (cur_rep < 8'd2)) begin
                  pattern_d[scan_q] = LED_ALL_OFF;
                end
              end else begin
                lit_d[scan_q] = 1'b0;
                if (is_key && (cur_rep > 8'd1)) begin
                  pattern_d[scan_q] = LED_ALL_ON;
                end
                rep_d[scan_q]   = rep_n;
                timer_d[scan_q] = (rep_n != '0) ? off_ticks(cur_mode) : '0;
              end
            end
          end
          if (emit_cur) begin
            out_load          = 1'b1;
            out_item.kind     = KIND_LED;
            out_item.led_word = emit_word;
            out_item.last     = ~|(emits_v & later_v);
          end
          if (scan_q == CH_IDX_W'(CHANNELS - 1)) begin
            state_d = BK_IDLE;
          end else begin
            scan_d = scan_q + 1'b1;
          end
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
      scan_q  <= '0;
    end else begin
      state_q <= state_d;
      scan_q  <= scan_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < CHANNELS; j++) begin
        timer_q[j]   <= '0;
        lit_q[j]     <= 1'b0;
        rep_q[j]     <= '0;
        mode_q[j]    <= '0;
        pattern_q[j] <= '0;
      end
    end else begin
      timer_q   <= timer_d;
      lit_q     <= lit_d;
      rep_q     <= rep_d;
      mode_q    <= mode_d;
      pattern_q <= pattern_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= out_item;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`ifndef NO_ASSERTIONS
  a_scan_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_SCAN) |-> (scan_q <= CH_IDX_W'(CHANNELS - 1)))
    else $error("channel scan index out of range");

  a_single_armed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(busy_v) <= 1)
    else $error("more than one channel armed");

  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_data_q.kind != KIND_LED)) |-> out_data_q.last)
    else $error("status beat not marked last");
`endif

endmodule

`default_nettype wire
